### src/sampled_curve_interpolator_core_defines.svh
// ----------------------------------------------------------------------------
// sampled_curve_interpolator_core_defines
// Assertion macros used by the interpolator core.
// ----------------------------------------------------------------------------
`ifndef SAMPLED_CURVE_INTERPOLATOR_CORE_DEFINES_SVH
`define SAMPLED_CURVE_INTERPOLATOR_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SCI_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define SCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg
// Shared constants and types of the sampled curve interpolator.
// ----------------------------------------------------------------------------
package sci_pkg;
  localparam int MaxPoints     = 64;
  localparam int IdxW          = $clog2(MaxPoints);
  localparam int CntW          = IdxW + 1;
  localparam int WaveW         = 16;
  localparam int ValW          = 32;
  localparam int ValueFracBits = 16;
  localparam int FracBits      = 16;

  localparam logic [0:0] ReqLoad  = 1'b0;
  localparam logic [0:0] ReqQuery = 1'b1;

  localparam logic [0:0] RegPointsInUse   = 1'b0;
  localparam logic [0:0] RegReflectantMode = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StSearch, StSearchWait, StRead0, StFetch, StFracDiv,
    StMul, StNormDiv, StOut
  } state_e;
endpackage

### src/sci_divider.sv
// ----------------------------------------------------------------------------
// sci_divider
// Restoring divider of unsigned 48-bit by 32-bit operands, one bit a cycle.
// ----------------------------------------------------------------------------
module sci_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [47:0] quotient_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [47:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q[31:0], quo_q[47]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

### src/sampled_curve_interpolator_core.sv
// ----------------------------------------------------------------------------
// sampled_curve_interpolator_core
// Piecewise linear interpolation over a loaded table of sample points.
// ----------------------------------------------------------------------------
// A load word is taken whenever the block is idle. A query inside the
// table span keeps the input stalled through one to seven binary-search
// steps (each a search state and a state waiting on the table memory),
// two table reads, and, when the segment rises, a pass of the shared
// one-bit-a-cycle divider to form the fraction. In reflectant mode with a
// table maximum above 1.0, normalization adds a second divider pass. A
// query outside the span skips the table reads and the divider. A finished
// result sits in an output register; load words are still accepted while
// it waits, query words stall until it is taken.
`include "sampled_curve_interpolator_core_defines.svh"
module sampled_curve_interpolator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type_i,
  input  logic [5:0]  point_index_i,
  input  logic [15:0] point_wavelength_i,
  input  logic signed [31:0] point_value_i,
  input  logic [15:0] query_wavelength_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] result_value_o,
  output logic        in_range_o
);
  localparam int IdxW = sci_pkg::IdxW;
  localparam int CntW = sci_pkg::CntW;
  localparam logic signed [31:0] One = 32'sd1 <<< sci_pkg::ValueFracBits;

  // Table memories: one write and one read port each.
  logic [15:0]        wave_mem  [sci_pkg::MaxPoints];
  logic signed [31:0] value_mem [sci_pkg::MaxPoints];
  logic [IdxW-1:0]    rd_addr;
  logic [15:0]        wave_rd_q;
  logic signed [31:0] value_rd_q;
  logic               we;

  logic [6:0]  points_q;
  logic        refl_q;
  logic signed [31:0] rmax_q;

  sci_pkg::state_e state_q, state_d;
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, n_q, n_d, mid;
  logic [15:0] q_q, q_d, w0_q, w0_d;
  logic signed [31:0] v0_q, v0_d, v1_q, v1_d;
  logic [15:0] t_q, t_d;
  logic signed [33:0] vres_q, vres_d;   // saturated into 32 bits later
  logic signed [33:0] diff;
  logic signed [51:0] prod;
  logic signed [52:0] rounded;
  logic signed [31:0] vint;
  logic neg_q, neg_d;
  logic signed [31:0] res_q, res_d;
  logic rng_q, rng_d, ov_q, ov_d;

  logic        div_start, div_busy, div_done;
  logic [47:0] div_num, div_quo;
  logic [31:0] div_den;
  logic [47:0] absv;

  sci_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num), .divisor_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quotient_o(div_quo)
  );

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_q != sci_pkg::StIdle)
                    || (ov_q && req_type_i == sci_pkg::ReqQuery);
  assign we = in_acc && req_type_i == sci_pkg::ReqLoad;
  assign mid = CntW'((lo_q + hi_q) >> 1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      wave_mem[point_index_i]  <= point_wavelength_i;
      value_mem[point_index_i] <= point_value_i;
    end
    wave_rd_q  <= wave_mem[rd_addr];
    value_rd_q <= value_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q <= 7'd2;
      refl_q   <= 1'b0;
      rmax_q   <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == sci_pkg::RegPointsInUse) points_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == sci_pkg::RegReflectantMode) refl_q <= cfg_data_i[0];
      if (we && (point_index_i == '0 || point_value_i > rmax_q)) rmax_q <= point_value_i;
    end
  end

  always_comb begin
    diff    = 34'(v1_q) - 34'(v0_q);
    prod    = 52'(diff) * $signed({1'b0, t_q});
    rounded = 53'(prod) + 53'sd32768;
    vint    = (vres_q > 34'sd2147483647) ? 32'sh7fffffff :
              (vres_q < -34'sd2147483648) ? 32'sh80000000 : vres_q[31:0];
    absv    = vint[31] ? 48'(-$signed({vint[31], vint})) : 48'(vint);
  end

  always_comb begin
    state_d = state_q;
    lo_d = lo_q; hi_d = hi_q; n_d = n_q; q_d = q_q;
    w0_d = w0_q; v0_d = v0_q; v1_d = v1_q;
    t_d = t_q; vres_d = vres_q; neg_d = neg_q;
    res_d = res_q; rng_d = rng_q; ov_d = ov_q;
    rd_addr = mid[IdxW-1:0];
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    if (out_acc) ov_d = 1'b0;
    case (state_q)
      sci_pkg::StIdle: begin
        if (in_acc && req_type_i == sci_pkg::ReqQuery) begin
          q_d = query_wavelength_i;
          lo_d = '0;
          if (points_q < 7'd2) n_d = CntW'(2);
          else if (points_q > 7'(sci_pkg::MaxPoints)) n_d = CntW'(sci_pkg::MaxPoints);
          else n_d = CntW'(points_q);
          hi_d = n_d;
          state_d = sci_pkg::StSearch;
        end
      end
      sci_pkg::StSearch: begin
        if (lo_q < hi_q) state_d = sci_pkg::StSearchWait;
        else if (lo_q == '0 || lo_q >= n_q) begin
          res_d = '0; rng_d = 1'b0;
          state_d = sci_pkg::StOut;
        end else begin
          rd_addr = IdxW'(lo_q - CntW'(1));
          state_d = sci_pkg::StRead0;
        end
      end
      sci_pkg::StSearchWait: begin
        if (wave_rd_q <= q_q) lo_d = mid + CntW'(1);
        else hi_d = mid;
        state_d = sci_pkg::StSearch;
      end
      sci_pkg::StRead0: begin
        // The lower point has arrived; the upper one is read next.
        w0_d = wave_rd_q; v0_d = value_rd_q;
        rd_addr = lo_q[IdxW-1:0];
        state_d = sci_pkg::StFetch;
      end
      sci_pkg::StFetch: begin
        v1_d = value_rd_q;
        if (wave_rd_q > w0_q && q_q >= w0_q) begin
          div_start = 1'b1;
          div_num = {16'(q_q - w0_q), 32'd0} >> 16;
          div_den = 32'(wave_rd_q - w0_q);
          state_d = sci_pkg::StFracDiv;
        end else begin
          t_d = '0;
          state_d = sci_pkg::StMul;
        end
      end
      sci_pkg::StFracDiv: begin
        if (div_done) begin
          t_d = (div_quo > 48'hFFFF) ? 16'hFFFF : div_quo[15:0];
          state_d = sci_pkg::StMul;
        end
      end
      sci_pkg::StMul: begin
        vres_d = 34'(v0_q) + 34'(rounded >>> sci_pkg::FracBits);
        state_d = sci_pkg::StOut;
        rng_d = 1'b1;
        res_d = vint; // overwritten below once vres is registered
        state_d = sci_pkg::StNormDiv;
        neg_d = 1'b0;
      end
      sci_pkg::StNormDiv: begin
        if (!div_busy && !div_done) begin
          res_d = vint;
          if (refl_q && rmax_q > One) begin
            div_start = 1'b1;
            div_num = absv << sci_pkg::ValueFracBits;
            div_den = rmax_q;
            neg_d = vint[31];
          end else state_d = sci_pkg::StOut;
        end else if (div_done) begin
          if (div_quo > 48'h7FFFFFFF) res_d = neg_q ? 32'sh80000001 : 32'sh7fffffff;
          else res_d = neg_q ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
          if (neg_q && div_quo > 48'h7FFFFFFF) res_d = 32'sh80000000;
          state_d = sci_pkg::StOut;
        end
      end
      sci_pkg::StOut: begin
        if (!ov_q || out_acc) begin
          ov_d = 1'b1;
          state_d = sci_pkg::StIdle;
        end
      end
      default: state_d = sci_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sci_pkg::StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; n_q <= n_d; q_q <= q_d;
    w0_q <= w0_d; v0_q <= v0_d; v1_q <= v1_d;
    t_q <= t_d; vres_q <= vres_d; neg_q <= neg_d;
    if (state_q == sci_pkg::StOut && (!ov_q || out_acc)) begin
      result_value_o <= res_q;
      in_range_o     <= rng_q;
    end
    res_q <= res_d; rng_q <= rng_d;
  end

  assign out_valid = ov_q;

  `SCI_ASSERT_IMPL(a_idle_on_accept, clk_i, rst_ni, in_acc, state_q == sci_pkg::StIdle, "word accepted while busy")
  `SCI_ASSERT_IMPL(a_out_zero, clk_i, rst_ni, out_valid && !in_range_o, result_value_o == '0, "out of range result not zero")
  `SCI_ASSERT_IMPL(a_div_start, clk_i, rst_ni, div_start, !div_busy, "divider restarted while busy")
endmodule

### tb/tb_sampled_curve_interpolator_core.sv
// ----------------------------------------------------------------------------
// tb_sampled_curve_interpolator_core
// Self-checking bench: loads sample tables, issues wavelength queries under
// several register settings and compares every result word with a local
// interpolation predictor, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sampled_curve_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 2500000;
  localparam int DrainCycles = 200;

  typedef struct {
    logic [0:0]         req;
    logic [5:0]         idx;
    logic [15:0]        wl;
    logic signed [31:0] val;
    logic [15:0]        qwl;
  } word_t;

  typedef struct {
    logic signed [31:0] value;
    logic               inr;
  } curve_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type_i = 1'b0;
  logic [5:0] point_index_i = '0;
  logic [15:0] point_wavelength_i = '0;
  logic signed [31:0] point_value_i = '0;
  logic [15:0] query_wavelength_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] result_value_o;
  logic in_range_o;

  sampled_curve_interpolator_core u_top (.*);

  // Predictor state.
  logic [15:0]        wave_mem [sci_pkg::MaxPoints];
  logic signed [31:0] value_mem [sci_pkg::MaxPoints];
  logic signed [31:0] peak_value = '0;
  logic [6:0]         span_cfg = 7'd2;
  logic               norm_cfg = 1'b0;

  word_t      pending_words[$];
  curve_res_t expected_curve[$];
  int  n_errors = 0;
  int  cycles = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  no_idle = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 65) return 0;
    if (r < 96) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Applies one accepted word to the table model and, for a query, gives its result.
  function automatic bit interpolate(input word_t w, output curve_res_t r);
    int unsigned n, lo, hi, mid, k;
    logic [31:0] t;
    logic [15:0] w0, w1;
    longint signed v0, v1, v, prod;
    if (w.req == sci_pkg::ReqLoad) begin
      wave_mem[w.idx]  = w.wl;
      value_mem[w.idx] = w.val;
      if (w.idx == 0 || w.val > peak_value) peak_value = w.val;
      return 1'b0;
    end
    n = span_cfg;
    if (n < 2) n = 2;
    if (n > sci_pkg::MaxPoints) n = sci_pkg::MaxPoints;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (wave_mem[mid] <= w.qwl) lo = mid + 1;
      else hi = mid;
    end
    k = lo;
    r.value = '0;
    r.inr = 1'b0;
    if (k == 0 || k >= n) return 1'b1;
    w0 = wave_mem[k-1];
    w1 = wave_mem[k];
    v0 = value_mem[k-1];
    v1 = value_mem[k];
    t = '0;
    if (w1 > w0 && w.qwl >= w0) begin
      t = ({16'b0, w.qwl - w0} << sci_pkg::FracBits) / {16'b0, w1 - w0};
      if (t > 32'hFFFF) t = 32'hFFFF;
    end
    prod = (v1 - v0) * longint'(t) + 64'sd32768;
    v = v0 + (prod >>> sci_pkg::FracBits);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    if (norm_cfg && longint'(peak_value) > (64'sd1 <<< sci_pkg::ValueFracBits)) begin
      v = (v * (64'sd1 <<< sci_pkg::ValueFracBits)) / longint'(peak_value);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
    end
    r.value = v[31:0];
    r.inr = 1'b1;
    return 1'b1;
  endfunction

  // Input driver: predicts on acceptance, then offers the next word or a gap.
  always @(posedge clk_i) begin
    curve_res_t res;
    word_t cur, nxt;
    logic nvalid;
    cycles <= cycles + 1;
    nvalid = in_valid;
    if (in_valid && !in_stall) begin
      cur.req = req_type_i;
      cur.idx = point_index_i;
      cur.wl  = point_wavelength_i;
      cur.val = point_value_i;
      cur.qwl = query_wavelength_i;
      if (interpolate(cur, res)) expected_curve.push_back(res);
      nvalid = 1'b0;
      in_gap <= pick_gap();
    end else if (!in_valid && rst_ni) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_words.size() > 0) begin
        nxt = pending_words.pop_front();
        req_type_i <= nxt.req;
        point_index_i <= nxt.idx;
        point_wavelength_i <= nxt.wl;
        point_value_i <= nxt.val;
        query_wavelength_i <= nxt.qwl;
        nvalid = 1'b1;
      end
    end
    if (in_valid && !in_stall && in_gap == 0 && pending_words.size() > 0 && no_idle) begin
      nxt = pending_words.pop_front();
      req_type_i <= nxt.req;
      point_index_i <= nxt.idx;
      point_wavelength_i <= nxt.wl;
      point_value_i <= nxt.val;
      query_wavelength_i <= nxt.qwl;
      nvalid = 1'b1;
    end
    in_valid <= nvalid;
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin
    curve_res_t exp_r;
    if (out_valid && !out_stall) begin
      if (expected_curve.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_errors < 10) $display("unexpected result word: value %0d in_range %0b",
                                    result_value_o, in_range_o);
      end else begin
        exp_r = expected_curve.pop_front();
        if (exp_r.value !== result_value_o || exp_r.inr !== in_range_o) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10)
            $display("result mismatch: expected value %0d in_range %0b, got %0d %0b",
                     exp_r.value, exp_r.inr, result_value_o, in_range_o);
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= (pick_gap() != 0);
      out_gap <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic word_t load_word(int idx, int wl, logic signed [31:0] val);
    word_t w;
    w.req = sci_pkg::ReqLoad;
    w.idx = idx[5:0];
    w.wl  = wl[15:0];
    w.val = val;
    w.qwl = 16'($urandom);
    return w;
  endfunction

  function automatic word_t query_word(int qwl);
    word_t w;
    w.req = sci_pkg::ReqQuery;
    w.idx = 6'($urandom);
    w.wl  = 16'($urandom);
    w.val = 32'($urandom);
    w.qwl = qwl[15:0];
    return w;
  endfunction

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(9);
    if (r < 3) return $signed(32'($urandom_range(131072))) - 32'sd65536;
    if (r < 8) return $signed(32'($urandom_range(524288))) - 32'sd262144;
    return $signed(32'($urandom));
  endfunction

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_curve.size() > 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sci_pkg::RegPointsInUse) span_cfg = data;
    else norm_cfg = data[0];
  endtask

  // Fills all entries: the first lim with increasing wavelengths from a random start, the rest at random.
  task automatic load_sorted_table(int lim);
    int wl, step;
    wl = $urandom_range(3000);
    step = (65535 - wl) / lim;
    for (int i = 0; i < sci_pkg::MaxPoints; i++) begin
      if (i < lim) begin
        pending_words.push_back(load_word(i, wl, rand_value()));
        wl += $urandom_range(step, 1);
        if (wl > 65535) wl = 65535;
      end else begin
        pending_words.push_back(load_word(i, $urandom_range(65535), rand_value()));
      end
    end
  endtask

  initial begin
    int spans[7];
    int lim, qlo, qhi;
    spans = '{2, 64, 0, 1, 127, 17, 40};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry gets written before the first query.
    for (int i = 0; i < sci_pkg::MaxPoints; i++)
      pending_words.push_back(load_word(i, 100 + i * 1000, 32'sd65536 * i));
    pending_words.push_back(load_word(0, 100, 32'sh8000_0000));
    pending_words.push_back(load_word(1, 1100, 32'sh7FFF_FFFF));
    // Reset span of two points.
    pending_words.push_back(query_word(0));
    pending_words.push_back(query_word(99));
    pending_words.push_back(query_word(100));
    pending_words.push_back(query_word(600));
    pending_words.push_back(query_word(1099));
    pending_words.push_back(query_word(1100));
    pending_words.push_back(query_word(65535));
    wait_idle();
    write_reg(sci_pkg::RegPointsInUse, 7'd64);
    write_reg(sci_pkg::RegReflectantMode, 7'd1);
    pending_words.push_back(query_word(650));
    pending_words.push_back(query_word(63099));
    pending_words.push_back(query_word(63100));
    // Wavelength out of order, then the maximum restarted by index zero.
    pending_words.push_back(load_word(5, 0, 32'sd70000));
    pending_words.push_back(query_word(4000));
    pending_words.push_back(query_word(5050));
    pending_words.push_back(load_word(0, 100, 32'sd32768));
    pending_words.push_back(query_word(30000));
    pending_words.push_back(load_word(7, 7100, 32'sd200000));
    pending_words.push_back(query_word(7600));
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(sci_pkg::RegPointsInUse, spans[ph][6:0]);
      write_reg(sci_pkg::RegReflectantMode, {6'b0, ph[0]});
      no_idle = (ph == 3);
      lim = spans[ph] < 2 ? 2 :
            (spans[ph] > sci_pkg::MaxPoints ? sci_pkg::MaxPoints : spans[ph]);
      load_sorted_table(lim);
      for (int j = 0; j < 195; j++) begin
        if ($urandom_range(99) < 8) begin
          pending_words.push_back(load_word($urandom_range(63), $urandom_range(65535),
                                            rand_value()));
        end else if ($urandom_range(99) < 85) begin
          qlo = wave_mem[0];
          qhi = 65535;
          pending_words.push_back(query_word($urandom_range(qhi, qlo)));
        end else begin
          pending_words.push_back(query_word(16'($urandom)));
        end
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && expected_curve.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
